// ----- hdl/optt_pkg.sv -----
// Shared types and constants for the timer table.
// Holds request/result codes, field widths and the packed table entry.
// No dependencies.
package optt_pkg;

  localparam int ID_W = 31;
  localparam int TIME_W = 32;
  localparam int TABLE_DEPTH_DEF = 16;
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);

  typedef enum logic [1:0] {
    CMD_SCHEDULE = 2'd0,
    CMD_CANCEL   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SCHEDULED = 2'd0,
    KIND_CANCEL    = 2'd1,
    KIND_DUE       = 2'd2,
    KIND_CLEARED   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] period;
    logic              rep;
  } entry_t;

  typedef struct packed {
    logic            valid;
    kind_t           kind;
    logic [ID_W-1:0] id;
    status_t         status;
    logic            rep;
    logic            last;
  } res_t;

endpackage

// ----- hdl/optt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module optt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/oneshot_periodic_timer_table.sv -----
// Top level of the timer table: request decode, scan sequencer, result register.
// Depends on optt_pkg and optt_ram (entry store).
//
//  channel | ports                      | handshake
//  --------+----------------------------+-----------------------------------
//  request | in_command .. in_target_id | taken when start & !busy
//  result  | out_kind .. out_last       | out_valid for one cycle, no stall
//
// Schedule and clear are answered in the cycle after the request.
// Cancel and tick on a non-empty table scan the N stored timers: one entry read
// from the entry RAM per cycle, compacted in place, then a closing state.
// Due timers come out at most one per cycle, during the scan and the closing state.
// Synchronous reset empties the table and sets the next id to 1.
module oneshot_periodic_timer_table #(
  parameter int TABLE_DEPTH = optt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_command,
  input  logic [optt_pkg::TIME_W-1:0] in_now,
  input  logic [optt_pkg::TIME_W-1:0] in_timeout,
  input  logic                       in_periodic,
  input  logic [optt_pkg::ID_W-1:0]  in_target_id,
  output logic                       out_valid,
  output logic [1:0]                 out_kind,
  output logic [optt_pkg::ID_W-1:0]  out_timer_id,
  output logic [1:0]                 out_status,
  output logic                       out_was_periodic,
  output logic                       out_last
);
  import optt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [ID_W-1:0]   tid_r, tid_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  wr_r, wr_nxt;
  logic              found_r, found_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic              pend_rep_r, pend_rep_nxt;
  res_t              res_r, res_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  entry_t            ent;
  entry_t            new_ent;
  logic              due;
  logic              drop;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  last_idx;

  optt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent      = entry_t'(ram_rdata);
  assign cnt_m1   = count_r - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign due      = (ent.deadline <= now_r);

  always_comb begin
    new_ent          = '0;
    new_ent.id       = next_id_r;
    new_ent.deadline = in_now + in_timeout;
    new_ent.period   = in_timeout;
    new_ent.rep      = in_periodic;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    next_id_nxt  = next_id_r;
    cmd_nxt      = cmd_r;
    now_nxt      = now_r;
    tid_nxt      = tid_r;
    idx_nxt      = idx_r;
    wr_nxt       = wr_r;
    found_nxt    = found_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_rep_nxt = pend_rep_r;
    res_nxt      = '0;
    ram_we       = 1'b0;
    ram_waddr    = wr_r[IDX_W-1:0];
    ram_wdata    = ent;
    ram_raddr    = idx_r + IDX_W'(1);
    drop         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = '0;
        if (start) begin
          cmd_nxt   = cmd_t'(in_command);
          now_nxt   = in_now;
          tid_nxt   = in_target_id;
          idx_nxt   = '0;
          wr_nxt    = '0;
          found_nxt = 1'b0;
          pend_v_nxt = 1'b0;
          unique case (cmd_t'(in_command))
            CMD_SCHEDULE: begin
              res_nxt.valid = 1'b1;
              res_nxt.kind  = KIND_SCHEDULED;
              res_nxt.last  = 1'b1;
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                res_nxt.status = STATUS_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = count_r[IDX_W-1:0];
                ram_wdata   = new_ent;
                count_nxt   = count_r + CNT_W'(1);
                next_id_nxt = (next_id_r == ID_MAX) ? ID_FIRST : next_id_r + ID_W'(1);
                res_nxt.id  = next_id_r;
                res_nxt.status = STATUS_OK;
              end
            end
            CMD_CANCEL: begin
              if (count_r == '0) begin
                res_nxt.valid  = 1'b1;
                res_nxt.kind   = KIND_CANCEL;
                res_nxt.id     = in_target_id;
                res_nxt.status = STATUS_NOT_FOUND;
                res_nxt.last   = 1'b1;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_TICK: begin
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              count_nxt     = '0;
              res_nxt.valid = 1'b1;
              res_nxt.kind  = KIND_CLEARED;
              res_nxt.last  = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (cmd_r == CMD_TICK) begin
          drop = due && !ent.rep;
          if (due) begin
            if (ent.rep) begin
              ram_wdata.deadline = now_r + ent.period;
            end
            if (pend_v_r) begin
              res_nxt.valid = 1'b1;
              res_nxt.kind  = KIND_DUE;
              res_nxt.id    = pend_id_r;
              res_nxt.rep   = pend_rep_r;
            end
            pend_v_nxt   = 1'b1;
            pend_id_nxt  = ent.id;
            pend_rep_nxt = ent.rep;
          end
        end else begin
          drop = !found_r && (ent.id == tid_r);
          if (drop) begin
            found_nxt = 1'b1;
          end
        end
        if (!drop) begin
          ram_we = 1'b1;
          wr_nxt = wr_r + CNT_W'(1);
        end
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == last_idx) begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        count_nxt  = wr_r;
        state_nxt  = ST_IDLE;
        pend_v_nxt = 1'b0;
        if (cmd_r == CMD_CANCEL) begin
          res_nxt.valid  = 1'b1;
          res_nxt.kind   = KIND_CANCEL;
          res_nxt.id     = tid_r;
          res_nxt.status = found_r ? STATUS_OK : STATUS_NOT_FOUND;
          res_nxt.last   = 1'b1;
        end else if (pend_v_r) begin
          res_nxt.valid = 1'b1;
          res_nxt.kind  = KIND_DUE;
          res_nxt.id    = pend_id_r;
          res_nxt.rep   = pend_rep_r;
          res_nxt.last  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      next_id_r <= ID_FIRST;
      pend_v_r  <= 1'b0;
      found_r   <= 1'b0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      pend_v_r  <= pend_v_nxt;
      found_r   <= found_nxt;
      res_r     <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    now_r      <= now_nxt;
    tid_r      <= tid_nxt;
    idx_r      <= idx_nxt;
    wr_r       <= wr_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_rep_r <= pend_rep_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = res_r.valid;
  assign out_kind         = res_r.kind;
  assign out_timer_id     = res_r.id;
  assign out_status       = res_r.status;
  assign out_was_periodic = res_r.rep;
  assign out_last         = res_r.last;

endmodule

// ----- hdl/optt_checker.sv -----
// Port-level checks for the timer table, attached by bind.
// Depends on optt_pkg and oneshot_periodic_timer_table.
module optt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic [1:0]                in_command,
  input logic                      out_valid,
  input logic [1:0]                out_kind,
  input logic [optt_pkg::ID_W-1:0] out_timer_id,
  input logic [1:0]                out_status,
  input logic                      out_last
);
  import optt_pkg::*;

  a_sched_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_SCHEDULE
    |=> out_valid && out_kind == KIND_SCHEDULED && out_last)
    else $error("schedule request without answer");

  a_clear_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command == CMD_CLEAR
    |=> out_valid && out_kind == KIND_CLEARED && out_timer_id == '0 && out_last)
    else $error("clear request without answer");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DUE |-> out_last)
    else $error("single-result request without last");

  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("results pending while idle");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SCHEDULED && out_status == STATUS_OK
    |-> out_timer_id != '0)
    else $error("zero id assigned");

endmodule

bind oneshot_periodic_timer_table optt_checker u_optt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_command   (in_command),
  .out_valid    (out_valid),
  .out_kind     (out_kind),
  .out_timer_id (out_timer_id),
  .out_status   (out_status),
  .out_last     (out_last)
);
